@@ rtl/dqad_pkg.sv @@
// ----------------------------------------------------------------------------
// dqad_pkg - shared definitions for the dual quadrature angle decoder
// Widths, register indexes, pipeline depth and the types passed between the
// decoder lanes, the angle units and the top level.
// ----------------------------------------------------------------------------
package dqad_pkg;

    // core widths
    localparam int COUNT_BITS     = 32;
    localparam int FILTER_BITS    = 10;
    localparam int SCALE_BITS     = 32;
    localparam int ANGLE_BITS     = 48;
    localparam int OUT_COUNT_BITS = 32;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int GLITCH_BITS    = 10;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_A = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_B = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GLITCH  = 2'd3;

    localparam logic [GLITCH_BITS-1:0] GLITCH_RESET = 10'd80;

    // angle arithmetic: Q2.30 product taken to Q.16, rounded at bit 14
    localparam int PROD_BITS  = COUNT_BITS + SCALE_BITS;
    localparam int FRAC_SHIFT = 14;
    localparam int WIDE_BITS  = (PROD_BITS + 1 > ANGLE_BITS + 1) ? PROD_BITS + 1
                                                                 : ANGLE_BITS + 1;

    // lane registers, magnitude, product, rounding, output register
    localparam int PIPE_STAGES = 5;

    typedef logic signed [COUNT_BITS-1:0] count_t;
    typedef logic        [ANGLE_BITS-1:0] angle_mag_t;

    // per-stage load strobes for the angle units
    typedef struct packed {
        logic mag_load;
        logic prod_load;
        logic round_load;
    } pipe_ctl_t;

    // per-transaction side information riding alongside the angle pipeline
    typedef struct packed {
        count_t count_a;
        count_t count_b;
        logic   skip_a;
        logic   skip_b;
        logic   en;
    } side_t;

endpackage

@@ rtl/dqad_lane.sv @@
// ----------------------------------------------------------------------------
// dqad_lane - one encoder: glitch filters, gray decode and saturating count
// Filters both pins of one encoder, decodes the filtered pair as x4 gray code
// and, while enabled, updates the signed accumulator once per accepted sample.
// ----------------------------------------------------------------------------
module dqad_lane
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic                              en,
    input  logic                              pin_one,
    input  logic                              pin_two,
    input  logic [dqad_pkg::GLITCH_BITS-1:0]  glitch_ticks,
    output dqad_pkg::count_t                  count,
    output logic                              skip
);
    import dqad_pkg::*;

    localparam logic [FILTER_BITS-1:0] HOLD_MAX  = {FILTER_BITS{1'b1}};
    localparam count_t                 COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam count_t                 COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_UP   = 2'd1;
    localparam logic [1:0] STEP_SKIP = 2'd2;
    localparam logic [1:0] STEP_DOWN = 2'd3;

    logic [1:0]             filt_reg, filt_next;
    logic [FILTER_BITS-1:0] hold_reg  [2];
    logic [FILTER_BITS-1:0] hold_next [2];
    logic [FILTER_BITS-1:0] hold_inc  [2];
    logic [FILTER_BITS-1:0] threshold;
    logic [1:0]             raw;
    logic [1:0]             step;
    count_t                 accum_reg, accum_next;
    logic                   skip_reg, skip_next;

    // position of a pin pair in the sequence 00,10,11,01 (one, two)
    function automatic logic [1:0] gray_index(input logic one, input logic two);
        logic [1:0] idx;
        case ({two, one})
            2'b00:   idx = 2'd0;
            2'b01:   idx = 2'd1;
            2'b11:   idx = 2'd2;
            default: idx = 2'd3;
        endcase
        return idx;
    endfunction

    assign raw = {pin_two, pin_one};

    // limit the threshold to what the hold counter can reach
    assign threshold = (32'(glitch_ticks) > 32'(HOLD_MAX)) ? HOLD_MAX
                                                           : FILTER_BITS'(glitch_ticks);

    // filter each pin: a differing level must hold for threshold samples
    always_comb
    begin
        filt_next = filt_reg;
        for (int i = 0; i < 2; i++)
        begin
            hold_inc[i] = (hold_reg[i] == HOLD_MAX) ? hold_reg[i]
                                                    : hold_reg[i] + 1'b1;
            if (raw[i] == filt_reg[i])
            begin
                hold_next[i] = '0;
            end
            else if (hold_inc[i] >= threshold)
            begin
                hold_next[i] = '0;
                filt_next[i] = raw[i];
            end
            else
            begin
                hold_next[i] = hold_inc[i];
            end
        end
    end

    // decode the filtered transition and advance the saturating count
    assign step = gray_index(filt_next[0], filt_next[1]) - gray_index(filt_reg[0], filt_reg[1]);

    always_comb
    begin
        accum_next = accum_reg;
        skip_next  = 1'b0;
        if (en)
        begin
            case (step)
                STEP_UP:
                begin
                    if (accum_reg != COUNT_MAX)
                        accum_next = accum_reg + 1'b1;
                end
                STEP_DOWN:
                begin
                    if (accum_reg != COUNT_MIN)
                        accum_next = accum_reg - 1'b1;
                end
                STEP_SKIP: skip_next = 1'b1;
                STEP_NONE: ;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg    <= '0;
            hold_reg[0] <= '0;
            hold_reg[1] <= '0;
            accum_reg   <= '0;
            skip_reg    <= 1'b0;
        end
        else if (load)
        begin
            filt_reg    <= filt_next;
            hold_reg[0] <= hold_next[0];
            hold_reg[1] <= hold_next[1];
            accum_reg   <= accum_next;
            skip_reg    <= skip_next;
        end
    end

    assign count = accum_reg;
    assign skip  = skip_reg;

endmodule

@@ rtl/dqad_angle.sv @@
// ----------------------------------------------------------------------------
// dqad_angle - angle magnitude pipeline for one encoder
// Takes the count magnitude, multiplies by the Q2.30 scale, then rounds to
// Q.16 and clamps the magnitude to the signed angle range. Three stages.
// ----------------------------------------------------------------------------
module dqad_angle
(
    input  logic                             clk,
    input  dqad_pkg::pipe_ctl_t              ctl,
    input  dqad_pkg::count_t                 count,
    input  logic [dqad_pkg::SCALE_BITS-1:0]  scale,
    output logic                             neg,
    output dqad_pkg::angle_mag_t             mag
);
    import dqad_pkg::*;

    localparam logic [WIDE_BITS-1:0] ROUND_BIAS  = WIDE_BITS'(1) << (FRAC_SHIFT - 1);
    localparam logic [WIDE_BITS-1:0] ANGLE_LIMIT = WIDE_BITS'(1) << (ANGLE_BITS - 1);

    logic                   neg_mag_reg, neg_prod_reg, neg_round_reg;
    logic [COUNT_BITS-1:0]  mag_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    angle_mag_t             round_reg;
    logic [WIDE_BITS-1:0]   rounded;

    // round half away from zero on the magnitude, then shift to Q.16
    assign rounded = (WIDE_BITS'(prod_reg) + ROUND_BIAS) >> FRAC_SHIFT;

    always_ff @(posedge clk)
    begin
        // magnitude of the count
        if (ctl.mag_load)
        begin
            neg_mag_reg <= count[COUNT_BITS-1];
            mag_reg     <= count[COUNT_BITS-1] ? COUNT_BITS'(-count) : COUNT_BITS'(count);
        end
        // multiply by the scale
        if (ctl.prod_load)
        begin
            neg_prod_reg <= neg_mag_reg;
            prod_reg     <= PROD_BITS'(mag_reg) * PROD_BITS'(scale);
        end
        // clamp the rounded magnitude at the most negative angle
        if (ctl.round_load)
        begin
            neg_round_reg <= neg_prod_reg;
            round_reg     <= (rounded >= ANGLE_LIMIT) ? ANGLE_LIMIT[ANGLE_BITS-1:0]
                                                      : rounded[ANGLE_BITS-1:0];
        end
    end

    assign neg = neg_round_reg;
    assign mag = round_reg;

endmodule

@@ rtl/dual_quadrature_angle_decoder.sv @@
// ----------------------------------------------------------------------------
// dual_quadrature_angle_decoder - two x4 quadrature decoders with angle output
// Glitch-filtered x4 counting of two encoders side by side, saturating counts
// and scaled angles in signed Q.16 radians, one result per sample.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-------------------------------------------
//  sample   | sample_valid/stall     | a_pin_one a_pin_two b_pin_one b_pin_two
//  result   | result_valid/stall     | count_a count_b angle_a angle_b skip_a/b
//  cfg      | cfg_valid/cfg_ready    | cfg_index cfg_data (ready always high)
//
//  One sample is accepted every cycle while sample_stall is low; each result
//  passes through the magnitude, multiply and rounding stages of the angle
//  units and the output register that follow the lane registers.
//  Reset clears counts, filters and hold counters; glitch_ticks resets to 80,
//  enable and scales to zero.
//  A stalled result holds the output register; earlier stages keep filling
//  until the pipeline is full, then sample_stall rises.
// ----------------------------------------------------------------------------
module dual_quadrature_angle_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    // sample channel
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic                                a_pin_one,
    input  logic                                a_pin_two,
    input  logic                                b_pin_one,
    input  logic                                b_pin_two,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [dqad_pkg::OUT_COUNT_BITS-1:0] count_a,
    output logic signed [dqad_pkg::OUT_COUNT_BITS-1:0] count_b,
    output logic signed [dqad_pkg::ANGLE_BITS-1:0]     angle_a,
    output logic signed [dqad_pkg::ANGLE_BITS-1:0]     angle_b,
    output logic                                skip_a,
    output logic                                skip_b,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dqad_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dqad_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import dqad_pkg::*;

    localparam int LAST = PIPE_STAGES - 1;
    localparam logic [ANGLE_BITS-1:0] ANGLE_POS_MAX = {1'b0, {(ANGLE_BITS-1){1'b1}}};

    // configuration registers
    logic                     enable_reg;
    logic [CFG_DATA_BITS-1:0] scale_a_reg, scale_b_reg;
    logic [GLITCH_BITS-1:0]   glitch_ticks_reg;

    // pipeline control
    logic [PIPE_STAGES-1:0] valid_reg, valid_next;
    logic [PIPE_STAGES-1:0] stage_ready, stage_load, stage_drain;
    pipe_ctl_t              angle_ctl;

    // lane outputs and side information
    count_t     lane_count_a, lane_count_b;
    logic       lane_skip_a, lane_skip_b;
    logic       en_lane_reg;
    side_t      side_lane;
    side_t      side_reg [3];
    logic       neg_a, neg_b;
    angle_mag_t mag_a, mag_b;

    // output register
    logic signed [OUT_COUNT_BITS-1:0] count_a_reg, count_b_reg;
    logic signed [ANGLE_BITS-1:0]     angle_a_reg, angle_b_reg;
    logic                             skip_a_reg, skip_b_reg;

    // apply sign, clamp the positive side and zero while disabled
    function automatic logic [ANGLE_BITS-1:0] signed_angle(input logic en, input logic neg,
                                                           input angle_mag_t mag);
        logic [ANGLE_BITS-1:0] res;
        if (!en)
            res = '0;
        else if (neg)
            res = -mag;
        else if (mag > ANGLE_POS_MAX)
            res = ANGLE_POS_MAX;
        else
            res = mag;
        return res;
    endfunction

    // take configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            scale_a_reg      <= '0;
            scale_b_reg      <= '0;
            glitch_ticks_reg <= GLITCH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLE:  enable_reg       <= cfg_data[0];
                REG_SCALE_A: scale_a_reg      <= cfg_data;
                REG_SCALE_B: scale_b_reg      <= cfg_data;
                REG_GLITCH:  glitch_ticks_reg <= cfg_data[GLITCH_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // advance each stage when the next one is free or moving on
    always_comb
    begin
        stage_ready[LAST] = !valid_reg[LAST] || !result_stall;
        for (int k = LAST - 1; k >= 0; k--)
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];

        stage_load[0] = sample_valid && stage_ready[0];
        for (int k = 1; k < PIPE_STAGES; k++)
            stage_load[k] = valid_reg[k-1] && stage_ready[k];

        stage_drain[LAST] = valid_reg[LAST] && !result_stall;
        for (int k = 0; k < LAST; k++)
            stage_drain[k] = stage_load[k+1];

        for (int k = 0; k < PIPE_STAGES; k++)
            valid_next[k] = stage_load[k] || (valid_reg[k] && !stage_drain[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign sample_stall = !stage_ready[0];

    assign angle_ctl.mag_load   = stage_load[1];
    assign angle_ctl.prod_load  = stage_load[2];
    assign angle_ctl.round_load = stage_load[3];

    // decoder lanes, one per encoder
    dqad_lane u_lane_a
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (stage_load[0]),
        .en           (enable_reg),
        .pin_one      (a_pin_one),
        .pin_two      (a_pin_two),
        .glitch_ticks (glitch_ticks_reg),
        .count        (lane_count_a),
        .skip         (lane_skip_a)
    );

    dqad_lane u_lane_b
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (stage_load[0]),
        .en           (enable_reg),
        .pin_one      (b_pin_one),
        .pin_two      (b_pin_two),
        .glitch_ticks (glitch_ticks_reg),
        .count        (lane_count_b),
        .skip         (lane_skip_b)
    );

    // capture enable alongside the lane registers
    always_ff @(posedge clk)
    begin
        if (stage_load[0])
            en_lane_reg <= enable_reg;
    end

    // carry counts and flags down with the angle pipeline
    assign side_lane.count_a = lane_count_a;
    assign side_lane.count_b = lane_count_b;
    assign side_lane.skip_a  = lane_skip_a;
    assign side_lane.skip_b  = lane_skip_b;
    assign side_lane.en      = en_lane_reg;

    always_ff @(posedge clk)
    begin
        if (stage_load[1])
            side_reg[0] <= side_lane;
        for (int j = 1; j < 3; j++)
        begin
            if (stage_load[j+1])
                side_reg[j] <= side_reg[j-1];
        end
    end

    // angle units
    dqad_angle u_angle_a
    (
        .clk   (clk),
        .ctl   (angle_ctl),
        .count (lane_count_a),
        .scale (scale_a_reg[SCALE_BITS-1:0]),
        .neg   (neg_a),
        .mag   (mag_a)
    );

    dqad_angle u_angle_b
    (
        .clk   (clk),
        .ctl   (angle_ctl),
        .count (lane_count_b),
        .scale (scale_b_reg[SCALE_BITS-1:0]),
        .neg   (neg_b),
        .mag   (mag_b)
    );

    // merge both lanes into the output register
    always_ff @(posedge clk)
    begin
        if (stage_load[LAST])
        begin
            count_a_reg <= OUT_COUNT_BITS'(side_reg[2].count_a);
            count_b_reg <= OUT_COUNT_BITS'(side_reg[2].count_b);
            angle_a_reg <= signed_angle(side_reg[2].en, neg_a, mag_a);
            angle_b_reg <= signed_angle(side_reg[2].en, neg_b, mag_b);
            skip_a_reg  <= side_reg[2].skip_a;
            skip_b_reg  <= side_reg[2].skip_b;
        end
    end

    assign result_valid = valid_reg[LAST];
    assign count_a      = count_a_reg;
    assign count_b      = count_b_reg;
    assign angle_a      = angle_a_reg;
    assign angle_b      = angle_b_reg;
    assign skip_a       = skip_a_reg;
    assign skip_b       = skip_b_reg;

endmodule

@@ rtl/dqad_checker.sv @@
// ----------------------------------------------------------------------------
// dqad_checker - port-level checks for the dual quadrature angle decoder
// Watches the sample and result channels of the top level; bound below.
// ----------------------------------------------------------------------------
module dqad_checker
(
    input logic                                      clk,
    input logic                                      rst_n,
    input logic                                      sample_stall,
    input logic                                      result_valid,
    input logic                                      result_stall,
    input logic signed [dqad_pkg::OUT_COUNT_BITS-1:0] count_a,
    input logic signed [dqad_pkg::OUT_COUNT_BITS-1:0] count_b,
    input logic signed [dqad_pkg::ANGLE_BITS-1:0]     angle_a,
    input logic signed [dqad_pkg::ANGLE_BITS-1:0]     angle_b
);
    import dqad_pkg::*;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
    else $error("stalled result dropped");

    // an empty output register never blocks the sample channel
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !sample_stall)
    else $error("sample stalled while the output register is empty");

    // zero count gives zero angle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && count_a == 0 && count_b == 0 |-> angle_a == 0 && angle_b == 0)
    else $error("non-zero angle for a zero count");

    // angle sign follows count sign
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (count_a > 0 ? angle_a >= 0 : angle_a <= 0)
                      && (count_b > 0 ? angle_b >= 0 : angle_b <= 0))
    else $error("angle sign disagrees with count sign");

endmodule

bind dual_quadrature_angle_decoder dqad_checker u_dqad_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .count_a      (count_a),
    .count_b      (count_b),
    .angle_a      (angle_a),
    .angle_b      (angle_b)
);

@@ dv/dual_quadrature_angle_decoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_quadrature_angle_decoder_test - self-checking bench for the decoder
// Drives pin samples from two encoders as gray-code walks with glitches and
// double steps, over a range of register settings. Every result is compared
// with a cycle-free model of the filters, counters and angle scaling.
// ----------------------------------------------------------------------------

typedef struct {
    logic signed [dqad_pkg::OUT_COUNT_BITS-1:0] count_a;
    logic signed [dqad_pkg::OUT_COUNT_BITS-1:0] count_b;
    logic signed [dqad_pkg::ANGLE_BITS-1:0]     angle_a;
    logic signed [dqad_pkg::ANGLE_BITS-1:0]     angle_b;
    logic                                       skip_a;
    logic                                       skip_b;
} quad_reading_t;

// Tracks filter levels, hold counters and counts; holds the readings due
class encoder_tracker;
    logic                                enabled;
    logic [dqad_pkg::SCALE_BITS-1:0]     scale_a;
    logic [dqad_pkg::SCALE_BITS-1:0]     scale_b;
    logic [dqad_pkg::GLITCH_BITS-1:0]    glitch;
    logic [3:0]                          levels;
    logic [dqad_pkg::FILTER_BITS-1:0]    hold [4];
    dqad_pkg::count_t                    total_a;
    dqad_pkg::count_t                    total_b;
    quad_reading_t                       due [$];
    int                                  errors;
    int                                  readings_seen;
    int                                  steps_seen;
    int                                  skips_seen;

    function new();
        enabled = 1'b0;
        scale_a = '0;
        scale_b = '0;
        glitch  = dqad_pkg::GLITCH_RESET;
        levels  = '0;
        foreach (hold[i])
            hold[i] = '0;
        total_a = '0;
        total_b = '0;
        errors = 0;
        readings_seen = 0;
        steps_seen = 0;
        skips_seen = 0;
    endfunction

    function void write_reg(logic [dqad_pkg::CFG_INDEX_BITS-1:0] index,
                            logic [dqad_pkg::CFG_DATA_BITS-1:0] data);
        case (index)
            dqad_pkg::REG_ENABLE:  enabled = data[0];
            dqad_pkg::REG_SCALE_A: scale_a = data[dqad_pkg::SCALE_BITS-1:0];
            dqad_pkg::REG_SCALE_B: scale_b = data[dqad_pkg::SCALE_BITS-1:0];
            dqad_pkg::REG_GLITCH:  glitch  = data[dqad_pkg::GLITCH_BITS-1:0];
            default: ;
        endcase
    endfunction

    // position of a {two, one} pin pair along 00, 01, 11, 10
    function logic [1:0] gray_slot(logic [1:0] pair);
        return pair[1] ? (pair[0] ? 2'd2 : 2'd3) : (pair[0] ? 2'd1 : 2'd0);
    endfunction

    // step one count by the filtered transition; report a double change
    function logic advance(inout dqad_pkg::count_t total, input logic [1:0] was,
                           input logic [1:0] now);
        logic [1:0]       delta;
        dqad_pkg::count_t top;
        delta = gray_slot(now) - gray_slot(was);
        top = '1;
        top[dqad_pkg::COUNT_BITS-1] = 1'b0;
        if (delta == 2'd1 && total != top)
            total = total + 1;
        else if (delta == 2'd3 && total != ~top)
            total = total - 1;
        if (delta == 2'd1 || delta == 2'd3)
            steps_seen++;
        if (delta == 2'd2)
            skips_seen++;
        return delta == 2'd2;
    endfunction

    // |count| * scale, rounded at bit 14 away from zero, signed and saturated
    function logic signed [dqad_pkg::ANGLE_BITS-1:0] angle_from(dqad_pkg::count_t total,
                                                               logic [31:0] scale);
        logic signed [63:0] wide;
        logic [63:0]        mag;
        logic [63:0]        r;
        logic [63:0]        lim;
        lim = 64'd1 << (dqad_pkg::ANGLE_BITS - 1);
        wide = total;
        mag = (wide < 0) ? -wide : wide;
        r = (mag * {32'd0, scale} + 64'd8192) >> dqad_pkg::FRAC_SHIFT;
        if (r > lim)
            r = lim;
        if (wide < 0)
            r = -r;
        else if (r >= lim)
            r = lim - 64'd1;
        return r[dqad_pkg::ANGLE_BITS-1:0];
    endfunction

    // note one accepted sample and queue the reading it must produce
    function void take_sample(logic [3:0] pins);
        logic [3:0]                       prior;
        logic [3:0]                       nf;
        logic [dqad_pkg::FILTER_BITS-1:0] c;
        logic [dqad_pkg::FILTER_BITS-1:0] cmax;
        logic [dqad_pkg::FILTER_BITS-1:0] thr;
        quad_reading_t                    want;
        cmax = '1;
        thr = (glitch > cmax) ? cmax : glitch;
        prior = levels;
        nf = prior;
        for (int i = 0; i < 4; i++)
        begin
            if (pins[i] == prior[i])
                hold[i] = '0;
            else
            begin
                c = hold[i];
                if (c != cmax)
                    c = c + 1'b1;
                if (c >= thr)
                begin
                    nf[i] = ~nf[i];
                    c = '0;
                end
                hold[i] = c;
            end
        end
        levels = nf;
        want.skip_a = 1'b0;
        want.skip_b = 1'b0;
        if (enabled)
        begin
            want.skip_a = advance(total_a, prior[1:0], nf[1:0]);
            want.skip_b = advance(total_b, prior[3:2], nf[3:2]);
        end
        want.count_a = total_a[dqad_pkg::OUT_COUNT_BITS-1:0];
        want.count_b = total_b[dqad_pkg::OUT_COUNT_BITS-1:0];
        want.angle_a = enabled ? angle_from(total_a, scale_a) : '0;
        want.angle_b = enabled ? angle_from(total_b, scale_b) : '0;
        due.push_back(want);
    endfunction

    function void compare(string tag, logic signed [63:0] want, logic signed [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
        end
    endfunction

    // compare one delivered reading with the oldest one due
    function void check_reading(quad_reading_t got);
        quad_reading_t want;
        readings_seen++;
        if (due.size() == 0)
        begin
            errors++;
            $display("%0t: result with no sample outstanding, expected none, actual count_a %0d",
                     $time, got.count_a);
            return;
        end
        want = due.pop_front();
        compare("count_a", want.count_a, got.count_a);
        compare("count_b", want.count_b, got.count_b);
        compare("angle_a", want.angle_a, got.angle_a);
        compare("angle_b", want.angle_b, got.angle_b);
        compare("skip_a", want.skip_a, got.skip_a);
        compare("skip_b", want.skip_b, got.skip_b);
    endfunction
endclass

module dual_quadrature_angle_decoder_test;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 60;

    logic clk;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_stall;
    logic a_pin_one = 1'b0;
    logic a_pin_two = 1'b0;
    logic b_pin_one = 1'b0;
    logic b_pin_two = 1'b0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [dqad_pkg::OUT_COUNT_BITS-1:0] count_a;
    logic signed [dqad_pkg::OUT_COUNT_BITS-1:0] count_b;
    logic signed [dqad_pkg::ANGLE_BITS-1:0]     angle_a;
    logic signed [dqad_pkg::ANGLE_BITS-1:0]     angle_b;
    logic skip_a;
    logic skip_b;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [dqad_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [dqad_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    encoder_tracker board = new();
    quad_reading_t  seen;

    // stimulus state: gray walk position per encoder and the pins held
    int         walk_pos [2] = '{0, 0};
    int         walk_left [2] = '{0, 0};
    int         walk_dir [2] = '{1, 1};
    logic [3:0] steady = 4'b0000;
    int         cur_glitch = dqad_pkg::GLITCH_RESET;
    int         samples_sent = 0;
    bit         gaps_on = 1'b1;
    bit         quiet = 1'b0;
    bit         squeeze_req = 1'b0;
    bit         squeeze_active = 1'b0;

    // opening samples {b_two, b_one, a_two, a_one}: full turns each way,
    // double changes on either encoder and on both together
    logic [3:0] opening [0:16] = '{
        4'b0000, 4'b0001, 4'b0011, 4'b0010, 4'b0000, 4'b1000, 4'b1100, 4'b0100,
        4'b0000, 4'b0011, 4'b1111, 4'b1100, 4'b0000, 4'b1010, 4'b0101, 4'b1111,
        4'b0000
    };

    dual_quadrature_angle_decoder dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // record every accepted transaction on the three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            if (sample_valid && !sample_stall)
                board.take_sample({b_pin_two, b_pin_one, a_pin_two, a_pin_one});
            if (result_valid && !result_stall)
            begin
                seen.count_a = count_a;
                seen.count_b = count_b;
                seen.angle_a = angle_a;
                seen.angle_b = angle_b;
                seen.skip_a  = skip_a;
                seen.skip_b  = skip_b;
                board.check_reading(seen);
            end
        end
    end

    // end the run when no transaction moves for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: watchdog, no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    // result side: random stall bursts, calm stretches, one long hold-off
    initial
    begin : receiver
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (squeeze_req && !squeeze_active)
            begin
                result_stall <= 1'b1;
                squeeze_active = 1'b1;
                n = 0;
                while (n < LONG_HOLD)
                begin
                    @(posedge clk);
                    n++;
                end
                result_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
                repeat ($urandom_range(20, 80)) @(posedge clk);
        end
    end

    // {two, one} pins for a walk position
    function automatic logic [1:0] gray_pair(int idx);
        case (idx & 3)
            0:       return 2'b00;
            1:       return 2'b01;
            2:       return 2'b11;
            default: return 2'b10;
        endcase
    endfunction

    // offer one sample, with an optional idle burst first; hold until taken
    task automatic send_pins(logic [3:0] pins);
        if (gaps_on && !quiet && $urandom_range(0, 5) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        {b_pin_two, b_pin_one, a_pin_two, a_pin_one} <= pins;
        do
            @(posedge clk);
        while (sample_stall);
        samples_sent++;
    endtask

    // walk both encoders, holding each step past the filter, with glitches
    task automatic send_walk(int n);
        int         r;
        int         noisy;
        logic [3:0] pins;
        for (int e = 0; e < 2; e++)
            walk_dir[e] = $urandom_range(0, 1) ? 1 : -1;
        noisy = (cur_glitch < 8) ? 15 : 400;
        repeat (n)
        begin
            for (int e = 0; e < 2; e++)
            begin
                if (walk_left[e] == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        walk_pos[e] = walk_pos[e] + walk_dir[e];
                    else if (r < 75)
                        walk_pos[e] = walk_pos[e] - walk_dir[e];
                    else if (r < 83)
                        walk_pos[e] = walk_pos[e] + 2;
                    walk_left[e] = ((cur_glitch > 1) ? cur_glitch : 1) + $urandom_range(0, 3);
                end
                walk_left[e]--;
            end
            steady = {gray_pair(walk_pos[1]), gray_pair(walk_pos[0])};
            pins = steady;
            if ($urandom_range(0, noisy) == 0)
                pins = steady ^ (4'b0001 << $urandom_range(0, 3));
            send_pins(pins);
        end
    endtask

    // one encoder A step held one sample short, dropped, then held in full
    task automatic filter_edge(int thr);
        logic [3:0] near;
        near = steady;
        near[1:0] = gray_pair(walk_pos[0] + 1);
        repeat (thr - 1) send_pins(near);
        send_pins(steady);
        repeat (thr) send_pins(near);
        walk_pos[0] = walk_pos[0] + 1;
        steady = near;
    endtask

    // drop valid and wait until every sample has produced its result
    task automatic drain();
        sample_valid <= 1'b0;
        while (board.readings_seen < samples_sent)
            @(posedge clk);
    endtask

    // write all four registers back to back
    task automatic set_config(logic en, logic [31:0] sa, logic [31:0] sbv,
                              logic [dqad_pkg::GLITCH_BITS-1:0] gt);
        logic [dqad_pkg::CFG_INDEX_BITS-1:0] regs [4];
        logic [dqad_pkg::CFG_DATA_BITS-1:0]  vals [4];
        regs[0] = dqad_pkg::REG_ENABLE;
        regs[1] = dqad_pkg::REG_SCALE_A;
        regs[2] = dqad_pkg::REG_SCALE_B;
        regs[3] = dqad_pkg::REG_GLITCH;
        vals[0] = {31'd0, en};
        vals[1] = sa;
        vals[2] = sbv;
        vals[3] = {22'd0, gt};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_glitch = gt;
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: decoder off, long filter
        send_walk(10);
        drain();

        // opening turns and double changes with an open filter
        set_config(1'b1, '1, '0, '0);
        foreach (opening[i])
            send_pins(opening[i]);
        walk_pos[0] = 0;
        walk_pos[1] = 0;
        walk_left[0] = 0;
        walk_left[1] = 0;
        steady = 4'b0000;
        send_walk(150);
        drain();

        set_config(1'b1, $urandom, $urandom, 10'd1);
        send_walk(250);
        drain();

        // disabled: filters keep tracking, counts hold
        set_config(1'b0, $urandom, $urandom, 10'd2);
        send_walk(120);
        drain();

        // long output hold-off while samples keep coming back to back
        set_config(1'b1, '0, '1, 10'd3);
        squeeze_req = 1'b1;
        wait (squeeze_active);
        gaps_on = 1'b0;
        send_walk(40);
        gaps_on = 1'b1;
        send_walk(200);
        repeat (8) send_pins(steady);
        drain();

        // filter thresholds: one sample short, then exactly enough
        set_config(1'b1, $urandom, $urandom, dqad_pkg::GLITCH_RESET);
        filter_edge(dqad_pkg::GLITCH_RESET);
        drain();

        send_walk(225);
        drain();

        // closing stretch with no idling on either side
        quiet = 1'b1;
        gaps_on = 1'b0;
        set_config(1'b1, $urandom, $urandom, 10'($urandom_range(0, 4)));
        send_walk(225);
        drain();
        repeat (dqad_pkg::PIPE_STAGES + 4) @(posedge clk);

        if (board.due.size() != 0)
        begin
            board.errors++;
            $display("%0t: results outstanding, expected 0, actual %0d",
                     $time, board.due.size());
        end
        $display("Covered %0d samples and %0d results: %0d count steps, %0d double changes,",
                 samples_sent, board.readings_seen, board.steps_seen, board.skips_seen);
        $display("filter thresholds 0 to 80, scales 0 to all ones, enabled and disabled.");
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/dqad_pkg.sv
rtl/dqad_lane.sv
rtl/dqad_angle.sv
rtl/dual_quadrature_angle_decoder.sv
rtl/dqad_checker.sv
dv/dual_quadrature_angle_decoder_test.sv
